// ===== design/clle_pkg.sv =====
`default_nettype none

package clle_pkg;

    // Default store size and fixed field widths
    localparam int CELLS_DEF    = 16;
    localparam int KIND_W       = 2;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int CELL_INDEX_W = 6;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 40;

    // Operation codes carried on the input tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_INS_FIRST = 2'd0,
        KIND_INS_LAST  = 2'd1,
        KIND_DELETE    = 2'd2,
        KIND_LIST      = 2'd3
    } t_kind;

    // Result codes carried on the output tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Link store write selection
    typedef enum logic [2:0] {
        LW_NONE      = 3'd0,
        LW_CUR_HEAD  = 3'd1,
        LW_CUR_NIL   = 3'd2,
        LW_CUR_NEW   = 3'd3,
        LW_PREV_NEXT = 3'd4,
        LW_CUR_FREE  = 3'd5
    } t_link_op;

    typedef enum logic [1:0] {
        HD_KEEP = 2'd0,
        HD_CUR  = 2'd1,
        HD_NEXT = 2'd2
    } t_head_op;

    typedef enum logic [1:0] {
        FR_KEEP = 2'd0,
        FR_NEXT = 2'd1,
        FR_CUR  = 2'd2
    } t_free_op;

    typedef enum logic [1:0] {
        CS_ZERO = 2'd0,
        CS_CUR  = 2'd1,
        CS_NEW  = 2'd2
    } t_cell_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic      start;     // latch beat, read free head or list head
        logic      adv;       // step to successor of current cell
        logic      rd_head;   // restart walk at list head
        logic      take;      // claim current cell from the free list
        t_link_op  link_op;
        t_head_op  head_op;
        t_free_op  free_op;
        logic      emit;      // load output register
        t_status   status;
        logic      with_elem;
        t_cell_sel cell_sel;
        logic      last;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_kind kind;
        logic  cur_cell;
        logic  next_cell;
        logic  prev_cell;
        logic  head_nil;
        logic  match;
        logic  steps_end;
        logic  steps_final;
        logic  slot_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/clle_ctrl.sv =====
`default_nettype none

module clle_ctrl
    import clle_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_kind i_kind,
    output logic       o_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INS  = 6'b000010,
        S_TAIL = 6'b000100,
        S_DEL  = 6'b001000,
        S_FREE = 6'b010000,
        S_LST  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    unique case (i_kind)
                        KIND_INS_FIRST, KIND_INS_LAST: n_state = S_INS;
                        KIND_DELETE:                   n_state = S_DEL;
                        default:                       n_state = S_LST;
                    endcase
                end
            end
            S_INS: begin
                if (i_stat.slot_free) begin
                    if (!i_stat.cur_cell) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_FULL;
                        o_cmd.last   = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.take    = 1'b1;
                        o_cmd.free_op = FR_NEXT;
                        if (i_stat.kind == KIND_INS_FIRST) begin
                            o_cmd.link_op  = LW_CUR_HEAD;
                            o_cmd.head_op  = HD_CUR;
                            o_cmd.emit     = 1'b1;
                            o_cmd.status   = ST_OK;
                            o_cmd.cell_sel = CS_CUR;
                            o_cmd.last     = 1'b1;
                            n_state        = S_IDLE;
                        end else if (i_stat.head_nil) begin
                            o_cmd.link_op  = LW_CUR_NIL;
                            o_cmd.head_op  = HD_CUR;
                            o_cmd.emit     = 1'b1;
                            o_cmd.status   = ST_OK;
                            o_cmd.cell_sel = CS_CUR;
                            o_cmd.last     = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            o_cmd.link_op = LW_CUR_NIL;
                            o_cmd.rd_head = 1'b1;
                            n_state       = S_TAIL;
                        end
                    end
                end
            end
            S_TAIL: begin
                // walk to the tail, then hook the new cell behind it
                if (i_stat.next_cell && !i_stat.steps_end) begin
                    o_cmd.adv = 1'b1;
                end else if (i_stat.slot_free) begin
                    o_cmd.link_op  = LW_CUR_NEW;
                    o_cmd.emit     = 1'b1;
                    o_cmd.status   = ST_OK;
                    o_cmd.cell_sel = CS_NEW;
                    o_cmd.last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DEL: begin
                if (i_stat.cur_cell && i_stat.match) begin
                    // unlink from predecessor or from the head
                    if (i_stat.prev_cell) begin
                        o_cmd.link_op = LW_PREV_NEXT;
                    end else begin
                        o_cmd.head_op = HD_NEXT;
                    end
                    n_state = S_FREE;
                end else if (!i_stat.cur_cell || i_stat.steps_end) begin
                    if (i_stat.slot_free) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_NOT_FOUND;
                        o_cmd.last   = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            S_FREE: begin
                if (i_stat.slot_free) begin
                    o_cmd.link_op  = LW_CUR_FREE;
                    o_cmd.free_op  = FR_CUR;
                    o_cmd.emit     = 1'b1;
                    o_cmd.status   = ST_OK;
                    o_cmd.cell_sel = CS_CUR;
                    o_cmd.last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_LST: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_stat.cur_cell) begin
                        o_cmd.status = ST_EMPTY;
                        o_cmd.last   = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.status    = ST_OK;
                        o_cmd.with_elem = 1'b1;
                        o_cmd.cell_sel  = CS_CUR;
                        o_cmd.last      = !i_stat.next_cell || i_stat.steps_final;
                        if (!i_stat.next_cell || i_stat.steps_final) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.adv = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/clle_datapath.sv =====
`default_nettype none

module clle_datapath
    import clle_pkg::*;
#(
    parameter int CELLS = CELLS_DEF
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_kind                 i_kind,
    input  wire logic [VALUE_W-1:0]    i_value,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output t_status                    o_status,
    output logic [VALUE_W-1:0]         o_element,
    output logic [CELL_INDEX_W-1:0]    o_cell_index,
    output logic                       o_last
);

    localparam int CW = $clog2(CELLS + 1);   // cell number plus null
    localparam int AW = $clog2(CELLS);       // store address
    localparam int SW = $clog2(CELLS + 1);   // walk step count
    localparam logic [CW-1:0] NIL = CW'(CELLS);

    // Stores
    logic [VALUE_W-1:0] r_elem_mem [CELLS];
    logic [CW-1:0]      r_link_mem [CELLS];
    logic [CELLS-1:0]   r_lvalid;

    // Walk and list registers
    logic [CW-1:0]      r_cur, r_prev, r_new, r_head, r_free;
    logic [SW-1:0]      r_steps;
    logic [VALUE_W-1:0] r_value;
    t_kind              r_kind;

    // Registered read data of the current cell
    logic [VALUE_W-1:0] r_q_elem;
    logic [CW-1:0]      r_q_link_raw;
    logic [CW-1:0]      r_q_link_def;
    logic               r_q_valid;

    logic [CW-1:0]      q_link, nx, ra;
    logic [AW-1:0]      ra_idx, cur_idx, prev_idx, lw_idx;
    logic [CW-1:0]      lw_data;
    logic               lw_en, re;
    logic [CW-1:0]      cell_val;

    // Successor of current cell, out-of-range link taken as null
    assign q_link   = r_q_valid ? r_q_link_raw : r_q_link_def;
    assign nx       = (q_link < NIL) ? q_link : NIL;
    assign cur_idx  = r_cur[AW-1:0];
    assign prev_idx = r_prev[AW-1:0];

    // Read address select
    always_comb begin
        ra = r_cur;
        re = 1'b0;
        if (i_cmd.start) begin
            re = 1'b1;
            ra = (i_kind == KIND_INS_FIRST || i_kind == KIND_INS_LAST) ? r_free : r_head;
        end else if (i_cmd.rd_head) begin
            re = 1'b1;
            ra = r_head;
        end else if (i_cmd.adv) begin
            re = 1'b1;
            ra = nx;
        end
        ra_idx = (ra < NIL) ? ra[AW-1:0] : '0;
    end

    // Link write select
    always_comb begin
        lw_en   = 1'b1;
        lw_idx  = cur_idx;
        lw_data = NIL;
        unique case (i_cmd.link_op)
            LW_NONE:      lw_en   = 1'b0;
            LW_CUR_HEAD:  lw_data = r_head;
            LW_CUR_NIL:   lw_data = NIL;
            LW_CUR_NEW:   lw_data = r_new;
            LW_PREV_NEXT: begin
                lw_idx  = prev_idx;
                lw_data = nx;
            end
            LW_CUR_FREE:  lw_data = r_free;
            default:      lw_en   = 1'b0;
        endcase
    end

    // Element store
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_elem_mem[cur_idx] <= r_value;
        end
        if (re) begin
            r_q_elem <= r_elem_mem[ra_idx];
        end
    end

    // Link store; an unwritten cell links to the next one
    always_ff @(posedge i_clk) begin
        if (lw_en) begin
            r_link_mem[lw_idx] <= lw_data;
        end
        if (re) begin
            r_q_link_raw <= r_link_mem[ra_idx];
            r_q_link_def <= CW'(ra_idx) + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvalid  <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (lw_en) begin
                r_lvalid[lw_idx] <= 1'b1;
            end
            if (re) begin
                r_q_valid <= r_lvalid[ra_idx] && !(lw_en && lw_idx == ra_idx && 1'b0);
            end
        end
    end

    // List and free heads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= NIL;
            r_free <= '0;
        end else begin
            unique case (i_cmd.head_op)
                HD_CUR:  r_head <= r_cur;
                HD_NEXT: r_head <= nx;
                default: r_head <= r_head;
            endcase
            unique case (i_cmd.free_op)
                FR_NEXT: r_free <= nx;
                FR_CUR:  r_free <= r_cur;
                default: r_free <= r_free;
            endcase
        end
    end

    // Walk cursor, predecessor and step count
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_prev  <= NIL;
            r_steps <= '0;
        end else if (i_cmd.rd_head) begin
            r_steps <= '0;
        end else if (i_cmd.adv) begin
            r_prev  <= r_cur;
            r_steps <= r_steps + SW'(1);
        end
        if (re) begin
            r_cur <= ra;
        end
        if (i_cmd.take) begin
            r_new <= r_cur;
        end
    end

    // Status to controller
    always_comb begin
        o_stat.kind        = r_kind;
        o_stat.cur_cell    = (r_cur < NIL);
        o_stat.next_cell   = (nx < NIL);
        o_stat.prev_cell   = (r_prev < NIL);
        o_stat.head_nil    = !(r_head < NIL);
        o_stat.match       = (r_q_elem == r_value);
        o_stat.steps_end   = (r_steps == SW'(CELLS));
        o_stat.steps_final = (r_steps == SW'(CELLS - 1));
        o_stat.slot_free   = !o_out_valid || i_out_ready;
    end

    // Output register
    always_comb begin
        unique case (i_cmd.cell_sel)
            CS_CUR:  cell_val = r_cur;
            CS_NEW:  cell_val = r_new;
            default: cell_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status     <= i_cmd.status;
            o_element    <= i_cmd.with_elem ? r_q_elem : '0;
            o_cell_index <= CELL_INDEX_W'(cell_val);
            o_last       <= i_cmd.last;
        end
    end

endmodule

`default_nettype wire

// ===== design/cursor_linked_list_engine.sv =====
// Operation: insert first takes the free head and returns its result; insert last and delete walk the list one
// cell per cycle; list returns its first result after reading the list head, then one result per cycle
// while the output accepts them, each held while the output stalls.
// Throughput: one operation at a time; the single read port of the link store sets the
// one-cell-per-cycle walk rate. Reset (i_rst_n low, synchronous) empties the list and
// chains all cells onto the free list at once through per-cell link valid bits.
`default_nettype none

module cursor_linked_list_engine
    import clle_pkg::*;
#(
    parameter int CELLS = CELLS_DEF
)
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input channel
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [31:0] value
    input  wire logic [KIND_W-1:0]      i_s_axis_tuser,  // [1:0] kind
    // result channel
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,  // [31:0] element, [37:32] cell_index
    output logic [STATUS_W-1:0]         o_m_axis_tuser,  // [1:0] status
    output logic                        o_m_axis_tlast   // last
);

    t_cmd                     cmd;
    t_stat                    stat;
    t_kind                    kind;
    t_status                  status;
    logic [VALUE_W-1:0]       element;
    logic [CELL_INDEX_W-1:0]  cell_index;

    assign kind = t_kind'(i_s_axis_tuser);

    clle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_kind  (kind),
        .o_ready (o_s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    clle_datapath #(
        .CELLS (CELLS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kind       (kind),
        .i_value      (i_s_axis_tdata[VALUE_W-1:0]),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_status     (status),
        .o_element    (element),
        .o_cell_index (cell_index),
        .o_last       (o_m_axis_tlast)
    );

    // Pack result beat
    assign o_m_axis_tdata = {{(OUT_TDATA_W - VALUE_W - CELL_INDEX_W){1'b0}}, cell_index, element};
    assign o_m_axis_tuser = status;

endmodule

`default_nettype wire
